// ===== hdl/lpg_pkg.sv =====
`timescale 1ns / 1ps

package lpg_pkg;

  // request kinds carried on the input tuser bit
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_kind_t;

  // motion of the minor coordinate per step
  typedef enum logic [1:0] {
    MINOR_HOLD = 2'b00,
    MINOR_INC  = 2'b01,
    MINOR_DEC  = 2'b11
  } minor_dir_t;

  // flags of a registered request
  typedef struct packed {
    logic step;
    logic dx_neg;
    logic dy_neg;
  } lpg_req_t;

  // engine status for the current request
  typedef struct packed {
    logic emit;
    logic last;
    logic active;
  } lpg_status_t;

endpackage

// ===== hdl/line_pixel_generator_core.sv =====
`timescale 1ns / 1ps

// Bresenham line pixel generator for all octants. A start word (tuser low)
// carries both endpoints; the block latches the line and returns the first
// endpoint at once. Each step word (tuser high) returns the next pixel of the
// line, with tlast set on the pixel that is the second endpoint; a step word
// while no line is running is consumed and returns nothing, and a start word
// drops any line in progress. The major axis is y only when |dy| > |dx|.
// Each word is held in an input register, where the endpoint deltas are
// formed; the engine then updates its line state in a single pass and the
// pixel is written to the output register, from which it is offered. A new
// word is taken every cycle as long as the output side keeps up. While a
// pixel waits to be taken, one more word can sit in the input register
// before the input stalls.
module line_pixel_generator_core #(
  parameter int COORD_BITS = 11
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // start_x, start_y, end_x, end_y from bit 0 up, zero padded to bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // req_type: 0 start a line, 1 next pixel
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // pixel_x, pixel_y from bit 0 up, zero padded to bytes
  output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_axis_tdata,
  // last_pixel
  output logic                                  m_axis_tlast
);
  import lpg_pkg::*;

  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

  // input register
  logic                  in_valid;
  lpg_req_t              in_req;
  logic [COORD_BITS-1:0] in_x0;
  logic [COORD_BITS-1:0] in_y0;
  logic [COORD_BITS-1:0] in_adx;
  logic [COORD_BITS-1:0] in_ady;

  // engine results
  logic [COORD_BITS-1:0] eng_x;
  logic [COORD_BITS-1:0] eng_y;
  lpg_status_t           eng_status;

  // output register
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic                  out_last;

  logic                  load;
  logic                  advance;

  // the engine moves when the output register is empty or being drained
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign load          = s_axis_tvalid && s_axis_tready;

  lpg_input_stage #(
    .COORD_BITS (COORD_BITS)
  ) u_input (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .advance  (advance),
    .req_type (s_axis_tuser),
    .start_x  (s_axis_tdata[COORD_BITS-1:0]),
    .start_y  (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x    (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y    (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .valid    (in_valid),
    .req      (in_req),
    .x0       (in_x0),
    .y0       (in_y0),
    .adx      (in_adx),
    .ady      (in_ady)
  );

  lpg_engine #(
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .req     (in_req),
    .x0      (in_x0),
    .y0      (in_y0),
    .adx     (in_adx),
    .ady     (in_ady),
    .pixel_x (eng_x),
    .pixel_y (eng_y),
    .status  (eng_status)
  );

  // result register; a step with no line running leaves it empty
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= eng_status.emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (advance) begin
      out_x    <= eng_x;
      out_y    <= eng_y;
      out_last <= eng_status.last;
    end
  end

  assign m_axis_tdata = OUT_W'({out_y, out_x});
  assign m_axis_tlast = out_last;

`ifndef SYNTHESIS
  // a start word always produces its first pixel
  a_start_emits: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_req.step) |=> m_axis_tvalid)
    else $error("start word did not produce a pixel");

  // a step with no line running produces no pixel
  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (advance && in_req.step && !eng_status.active) |=> !m_axis_tvalid)
    else $error("idle step produced a pixel");

  // the final pixel of a line leaves the engine idle
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (advance && eng_status.emit && eng_status.last) |=> !eng_status.active)
    else $error("line still active after its last pixel");
`endif

endmodule

// ===== hdl/lpg_input_stage.sv =====
`timescale 1ns / 1ps

module lpg_input_stage #(
  parameter int COORD_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  advance,
  input  logic                  req_type,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  valid,
  output lpg_pkg::lpg_req_t     req,
  output logic [COORD_BITS-1:0] x0,
  output logic [COORD_BITS-1:0] y0,
  output logic [COORD_BITS-1:0] adx,
  output logic [COORD_BITS-1:0] ady
);
  import lpg_pkg::*;

  logic [COORD_BITS:0] dx;
  logic [COORD_BITS:0] dy;
  logic [COORD_BITS:0] dx_mag;
  logic [COORD_BITS:0] dy_mag;
  lpg_req_t            req_next;

  // endpoint deltas and their magnitudes, done before the register
  always_comb begin
    dx              = {1'b0, end_x} - {1'b0, start_x};
    dy              = {1'b0, end_y} - {1'b0, start_y};
    dx_mag          = dx[COORD_BITS] ? -dx : dx;
    dy_mag          = dy[COORD_BITS] ? -dy : dy;
    req_next.step   = (req_type == REQ_STEP);
    req_next.dx_neg = dx[COORD_BITS];
    req_next.dy_neg = dy[COORD_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
    if (load) begin
      req <= req_next;
      x0  <= start_x;
      y0  <= start_y;
      adx <= dx_mag[COORD_BITS-1:0];
      ady <= dy_mag[COORD_BITS-1:0];
    end
  end

endmodule

// ===== hdl/lpg_engine.sv =====
`timescale 1ns / 1ps

module lpg_engine #(
  parameter int COORD_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  lpg_pkg::lpg_req_t     req,
  input  logic [COORD_BITS-1:0] x0,
  input  logic [COORD_BITS-1:0] y0,
  input  logic [COORD_BITS-1:0] adx,
  input  logic [COORD_BITS-1:0] ady,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output lpg_pkg::lpg_status_t  status
);
  import lpg_pkg::*;

  localparam int DW = COORD_BITS + 3;

  logic [COORD_BITS-1:0] major_pos,     major_pos_next;
  logic [COORD_BITS-1:0] minor_pos,     minor_pos_next;
  logic [DW-1:0]         decision_term, decision_term_next;
  logic [COORD_BITS-1:0] steps_left,    steps_left_next;
  logic [COORD_BITS-1:0] major_len,     major_len_next;
  logic [COORD_BITS-1:0] minor_len,     minor_len_next;
  logic                  major_dir_neg, major_dir_neg_next;
  minor_dir_t            minor_dir,     minor_dir_next;
  logic                  axes_swapped,  axes_swapped_next;
  logic                  line_active,   line_active_next;

  logic                  swap;
  logic                  min_neg;
  logic [DW-1:0]         min_x2;
  logic [DW-1:0]         maj_x2;
  logic                  term_pos;

  always_comb begin
    major_pos_next     = major_pos;
    minor_pos_next     = minor_pos;
    decision_term_next = decision_term;
    steps_left_next    = steps_left;
    major_len_next     = major_len;
    minor_len_next     = minor_len;
    major_dir_neg_next = major_dir_neg;
    minor_dir_next     = minor_dir;
    axes_swapped_next  = axes_swapped;
    line_active_next   = line_active;
    status.emit        = 1'b0;

    swap     = (ady > adx);
    min_neg  = swap ? req.dx_neg : req.dy_neg;
    min_x2   = {2'b00, minor_len, 1'b0};
    maj_x2   = {2'b00, major_len, 1'b0};
    term_pos = !decision_term[DW-1] && (decision_term != '0);

    if (!req.step) begin
      // new line: pick the major axis and seed the error term
      axes_swapped_next  = swap;
      major_pos_next     = swap ? y0 : x0;
      minor_pos_next     = swap ? x0 : y0;
      major_len_next     = swap ? ady : adx;
      minor_len_next     = swap ? adx : ady;
      major_dir_neg_next = swap ? req.dy_neg : req.dx_neg;
      if (minor_len_next == '0) begin
        minor_dir_next = MINOR_HOLD;
      end else if (min_neg) begin
        minor_dir_next = MINOR_DEC;
      end else begin
        minor_dir_next = MINOR_INC;
      end
      decision_term_next = {2'b00, minor_len_next, 1'b0} - {3'b000, major_len_next};
      steps_left_next    = major_len_next;
      line_active_next   = (major_len_next != '0);
      status.emit        = 1'b1;
    end else if (line_active) begin
      major_pos_next = major_dir_neg ? major_pos - COORD_BITS'(1)
                                     : major_pos + COORD_BITS'(1);
      if (term_pos) begin
        decision_term_next = decision_term - maj_x2 + min_x2;
        case (minor_dir)
          MINOR_INC: minor_pos_next = minor_pos + COORD_BITS'(1);
          MINOR_DEC: minor_pos_next = minor_pos - COORD_BITS'(1);
          default:   minor_pos_next = minor_pos;
        endcase
      end else begin
        decision_term_next = decision_term + min_x2;
      end
      steps_left_next  = steps_left - COORD_BITS'(1);
      line_active_next = (steps_left_next != '0);
      status.emit      = 1'b1;
    end

    status.last   = !line_active_next;
    status.active = line_active;
    pixel_x       = axes_swapped_next ? minor_pos_next : major_pos_next;
    pixel_y       = axes_swapped_next ? major_pos_next : minor_pos_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      major_pos     <= '0;
      minor_pos     <= '0;
      decision_term <= '0;
      steps_left    <= '0;
      major_len     <= '0;
      minor_len     <= '0;
      major_dir_neg <= 1'b0;
      minor_dir     <= MINOR_HOLD;
      axes_swapped  <= 1'b0;
      line_active   <= 1'b0;
    end else if (fire) begin
      major_pos     <= major_pos_next;
      minor_pos     <= minor_pos_next;
      decision_term <= decision_term_next;
      steps_left    <= steps_left_next;
      major_len     <= major_len_next;
      minor_len     <= minor_len_next;
      major_dir_neg <= major_dir_neg_next;
      minor_dir     <= minor_dir_next;
      axes_swapped  <= axes_swapped_next;
      line_active   <= line_active_next;
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// line pixel generator bench: start and step words go in on the slave stream,
// a local Bresenham tracer predicts each pixel as the word is accepted, and
// every pixel taken off the master stream is checked against the oldest
// prediction, field by field
module tb;
  import lpg_pkg::*;

  localparam int CB       = 11;
  localparam int IN_W     = ((4*CB+7)/8)*8;
  localparam int OUT_W    = ((2*CB+7)/8)*8;
  localparam int MAX_CYC  = 300000;
  localparam int COORD_HI = (1 << CB) - 1;

  typedef logic [CB-1:0] coord_t;

  typedef struct {
    req_kind_t kind;
    coord_t    sx;
    coord_t    sy;
    coord_t    ex;
    coord_t    ey;
  } line_req_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  line_pixel_generator_core #(
    .COORD_BITS(CB)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // tracer state, a private copy of the line being drawn
  coord_t     trace_major;
  coord_t     trace_minor;
  int         err_term;
  int         steps_rem;
  int         len_major;
  int         len_minor;
  bit         major_down;
  minor_dir_t minor_step;
  bit         y_major;
  bit         tracing;

  pixel_t expected_pixels[$];

  int  error_count   = 0;
  int  words_counted = 0;
  int  lines_started = 0;
  int  pixels_seen   = 0;
  int  line_ends     = 0;
  int  cycle_count   = 0;

  bit  src_gaps_on    = 1'b0;
  bit  sink_stalls_on = 1'b0;
  int  hold_pending   = 0;
  int  stall_left     = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // advance the tracer by one word, returns 1 when a pixel comes out
  function automatic bit trace_pixel(input line_req_t r, output pixel_t p);
    int dx, dy, adx, ady, dmaj, dmin;
    if (r.kind == REQ_START) begin
      dx  = int'(r.ex) - int'(r.sx);
      dy  = int'(r.ey) - int'(r.sy);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      y_major = ady > adx;
      if (y_major) begin
        trace_major = r.sy;
        trace_minor = r.sx;
        dmaj = dy;
        dmin = dx;
      end else begin
        trace_major = r.sx;
        trace_minor = r.sy;
        dmaj = dx;
        dmin = dy;
      end
      len_major  = dmaj < 0 ? -dmaj : dmaj;
      len_minor  = dmin < 0 ? -dmin : dmin;
      major_down = dmaj < 0;
      minor_step = dmin > 0 ? MINOR_INC : (dmin < 0 ? MINOR_DEC : MINOR_HOLD);
      err_term   = 2*len_minor - len_major;
      steps_rem  = len_major;
      tracing    = steps_rem != 0;
    end else begin
      if (!tracing) return 1'b0;
      trace_major = major_down ? trace_major - coord_t'(1) : trace_major + coord_t'(1);
      if (err_term > 0) begin
        err_term -= 2*len_major;
        if (minor_step == MINOR_INC) trace_minor = trace_minor + coord_t'(1);
        else if (minor_step == MINOR_DEC) trace_minor = trace_minor - coord_t'(1);
      end
      err_term += 2*len_minor;
      steps_rem--;
      if (steps_rem == 0) tracing = 1'b0;
    end
    p.x    = y_major ? trace_minor : trace_major;
    p.y    = y_major ? trace_major : trace_minor;
    p.last = !tracing;
    return 1'b1;
  endfunction

  // offer one word, wait for the handshake, then log the predicted pixel
  task automatic send_word(input line_req_t r);
    pixel_t p;
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {{(IN_W-4*CB){1'b0}}, r.ey, r.ex, r.sy, r.sx};
    do @(posedge clk); while (!s_axis_tready);
    if (r.kind == REQ_START || tracing) words_counted++;
    if (r.kind == REQ_START) lines_started++;
    if (trace_pixel(r, p)) expected_pixels.push_back(p);
  endtask

  function automatic line_req_t make_step();
    line_req_t r;
    r.kind = REQ_STEP;
    r.sx = coord_t'($urandom);
    r.sy = coord_t'($urandom);
    r.ex = coord_t'($urandom);
    r.ey = coord_t'($urandom);
    return r;
  endfunction

  function automatic coord_t near_coord(input coord_t c, input int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2*span)) - span;
    if (v < 0) v = 0;
    if (v > COORD_HI) v = COORD_HI;
    return coord_t'(v);
  endfunction

  function automatic line_req_t make_start(input coord_t sx, sy, ex, ey);
    line_req_t r;
    r.kind = REQ_START;
    r.sx = sx;
    r.sy = sy;
    r.ex = ex;
    r.ey = ey;
    return r;
  endfunction

  task automatic send_steps(input int n);
    repeat (n) send_word(make_step());
  endtask

  // one line: maybe stray steps first, a start, then a run of steps that
  // finishes the line, runs past its end, or gets cut off by the next start
  task automatic run_line_sequence();
    line_req_t r;
    int        span;
    int        mode;
    r = make_step();
    if ($urandom_range(0, 9) == 0) send_steps($urandom_range(1, 2));
    r.kind = REQ_START;
    case ($urandom_range(0, 9))
      0: begin
        r.ex = coord_t'($urandom);
        r.ey = coord_t'($urandom);
      end
      1: begin
        r.ex = r.sx;
        r.ey = r.sy;
      end
      default: begin
        span = $urandom_range(1, 12);
        r.ex = near_coord(r.sx, span);
        r.ey = near_coord(r.sy, span);
      end
    endcase
    send_word(r);
    if (steps_rem > 30) begin
      send_steps($urandom_range(0, 20));
    end else begin
      mode = $urandom_range(0, 19);
      if (mode < 14) send_steps(steps_rem);
      else if (mode < 17) send_steps(steps_rem + $urandom_range(1, 3));
      else if (steps_rem > 0) send_steps($urandom_range(0, steps_rem - 1));
    end
  endtask

  // zero-length lines at both corners, then a step with nothing running
  task automatic t_zero_length();
    send_word(make_start('0, '0, '0, '0));
    send_word(make_start(coord_t'(COORD_HI), coord_t'(COORD_HI),
                         coord_t'(COORD_HI), coord_t'(COORD_HI)));
    send_steps(1);
  endtask

  // full-span diagonals (x wins the tie), a restart mid-line, a short
  // leftward line run to its end and past it
  task automatic t_extremes();
    send_word(make_start('0, '0, coord_t'(COORD_HI), coord_t'(COORD_HI)));
    send_steps(2);
    send_word(make_start(coord_t'(COORD_HI), '0, '0, coord_t'(COORD_HI)));
    send_steps(2);
    send_word(make_start(coord_t'(COORD_HI), coord_t'(COORD_HI),
                         coord_t'(COORD_HI-3), coord_t'(COORD_HI)));
    send_steps(4);
  endtask

  // y-major line with x going backward
  task automatic t_steep_line();
    send_word(make_start(11'd12, 11'd10, 11'd10, 11'd17));
    send_steps(7);
  endtask

  task automatic t_random_lines(input int target);
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    while (words_counted < target) run_line_sequence();
  endtask

  // receiver holds off while the sender keeps pushing, so the block backs up
  task automatic t_backpressure();
    int start_words;
    sink_stalls_on = 1'b0;
    src_gaps_on    = 1'b0;
    start_words    = words_counted;
    hold_pending   = 200;
    while (words_counted < start_words + 40) run_line_sequence();
  endtask

  task automatic t_streaming(input int target);
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    while (words_counted < target) run_line_sequence();
  endtask

  // receiver side: random stall bursts, plus one long counted hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_pending > 0) begin
        stall_left   = hold_pending - 1;
        hold_pending = 0;
        m_axis_tready <= 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // pixel checker
  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
                                  m_axis_tdata[CB-1:0], m_axis_tdata[2*CB-1:CB]));
      end else begin
        exp_px = expected_pixels.pop_front();
        if (m_axis_tdata[CB-1:0] !== exp_px.x)
          report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                    m_axis_tdata[CB-1:0], exp_px.x));
        if (m_axis_tdata[2*CB-1:CB] !== exp_px.y)
          report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                    m_axis_tdata[2*CB-1:CB], exp_px.y));
        if (m_axis_tlast !== exp_px.last)
          report_mismatch($sformatf("last_pixel %0b, expected %0b",
                                    m_axis_tlast, exp_px.last));
        if (exp_px.last) line_ends++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYC) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    t_zero_length();
    t_extremes();
    t_steep_line();
    t_random_lines(380);
    t_backpressure();
    t_random_lines(510);
    t_streaming(650);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d words over %0d lines incl. restarts, idle steps and a long stall",
             words_counted, lines_started);
    $display("compared %0d pixels, %0d of them line ends", pixels_seen, line_ends);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
